FILE: sv/calu_pkg.sv
// calu_pkg: beat types, operation codes and the mid-pipeline bundle for the alu
// used by calu_arith and cpu_alu_with_flags; depends on nothing else
package calu_pkg;

  localparam int unsigned OP_W = 6;

  typedef logic [OP_W-1:0] op_code_t;

  // operation codes
  localparam op_code_t OP_ADD   = 6'd0;
  localparam op_code_t OP_ADC   = 6'd1;
  localparam op_code_t OP_SUB   = 6'd2;
  localparam op_code_t OP_SBC   = 6'd3;
  localparam op_code_t OP_AND   = 6'd4;
  localparam op_code_t OP_XOR   = 6'd5;
  localparam op_code_t OP_OR    = 6'd6;
  localparam op_code_t OP_CP    = 6'd7;
  localparam op_code_t OP_INC   = 6'd8;
  localparam op_code_t OP_DEC   = 6'd9;
  localparam op_code_t OP_ADD16 = 6'd10;
  localparam op_code_t OP_ADC16 = 6'd11;
  localparam op_code_t OP_ADDSP = 6'd12;
  localparam op_code_t OP_INC16 = 6'd13;
  localparam op_code_t OP_DEC16 = 6'd14;
  localparam op_code_t OP_DAA   = 6'd15;
  localparam op_code_t OP_CPL   = 6'd16;
  localparam op_code_t OP_CCF   = 6'd17;
  localparam op_code_t OP_SCF   = 6'd18;
  localparam op_code_t OP_RLCA  = 6'd19;
  localparam op_code_t OP_RRCA  = 6'd20;
  localparam op_code_t OP_RLA   = 6'd21;
  localparam op_code_t OP_RRA   = 6'd22;
  localparam op_code_t OP_RLC   = 6'd23;
  localparam op_code_t OP_RRC   = 6'd24;
  localparam op_code_t OP_RL    = 6'd25;
  localparam op_code_t OP_RR    = 6'd26;
  localparam op_code_t OP_SLA   = 6'd27;
  localparam op_code_t OP_SRA   = 6'd28;
  localparam op_code_t OP_SRL   = 6'd29;
  localparam op_code_t OP_SWAP  = 6'd30;
  localparam op_code_t OP_BIT   = 6'd31;
  localparam op_code_t OP_SET   = 6'd32;
  localparam op_code_t OP_RES   = 6'd33;

  // daa adjust constants
  localparam logic [7:0] DAA_HI_LIMIT = 8'h9a;
  localparam logic [3:0] DAA_LO_LIMIT = 4'ha;
  localparam logic [7:0] DAA_ADD_HI   = 8'h60;
  localparam logic [7:0] DAA_ADD_LO   = 8'h06;
  localparam logic [7:0] DAA_SUB_BOTH = 8'h9a;
  localparam logic [7:0] DAA_SUB_HI   = 8'ha0;
  localparam logic [7:0] DAA_SUB_LO   = 8'hfa;

  // input beat
  typedef struct packed {
    op_code_t    op;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic        zero_in;
    logic        subtract_in;
    logic        half_carry_in;
    logic        carry_in;
  } in_t;

  // result beat
  typedef struct packed {
    logic [15:0] result;
    logic        zero_out;
    logic        subtract_out;
    logic        half_carry_out;
    logic        carry_out;
  } out_t;

  // adder results handed from the arithmetic stage to the select stage
  typedef struct packed {
    op_code_t    op;
    logic [15:0] a16;
    logic [2:0]  bit_index;
    logic        zi;
    logic        ni;
    logic        hi;
    logic        ci;
    logic [8:0]  add9;
    logic        add_h;
    logic [8:0]  sub9;
    logic        sub_h;
    logic [7:0]  and8;
    logic [7:0]  xor8;
    logic [7:0]  or8;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [16:0] sum17;
    logic        sum_h;
    logic [15:0] sp16;
    logic [15:0] inc16;
    logic [15:0] dec16;
    logic [7:0]  daa8;
    logic        daa_c;
  } mid_t;

endpackage

FILE: sv/calu_arith.sv
// calu_arith: adder stage of the alu, all carry chains of one beat side by side
// depends on calu_pkg for in_t and mid_t
module calu_arith (
  input  calu_pkg::in_t  in_beat,
  output calu_pkg::mid_t mid_beat
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] a16;
  logic [15:0] b16;
  logic        add_cin;
  logic        sub_cin;
  logic        sum_cin;
  logic [8:0]  add9;
  logic [8:0]  sub9;
  logic [16:0] sum17;
  logic [7:0]  daa_adj;
  logic        daa_c;

  assign a16 = in_beat.operand_a;
  assign b16 = in_beat.operand_b;
  assign a   = a16[7:0];
  assign b   = b16[7:0];

  // carry selects
  assign add_cin = (in_beat.op == calu_pkg::OP_ADC)   ? in_beat.carry_in : 1'b0;
  assign sub_cin = (in_beat.op == calu_pkg::OP_SBC)   ? in_beat.carry_in : 1'b0;
  assign sum_cin = (in_beat.op == calu_pkg::OP_ADC16) ? in_beat.carry_in : 1'b0;

  // 8 and 16 bit adders; bit 8 of the difference is the borrow
  assign add9  = {1'b0, a} + {1'b0, b} + {8'h00, add_cin};
  assign sub9  = {1'b0, a} - {1'b0, b} - {8'h00, sub_cin};
  assign sum17 = {1'b0, a16} + {1'b0, b16} + {16'h0000, sum_cin};

  // decimal adjust amount and carry
  always_comb begin
    daa_adj = 8'h00;
    daa_c   = in_beat.carry_in;
    if (in_beat.subtract_in) begin
      if (in_beat.carry_in && in_beat.half_carry_in) begin
        daa_adj = calu_pkg::DAA_SUB_BOTH;
      end else if (in_beat.carry_in) begin
        daa_adj = calu_pkg::DAA_SUB_HI;
      end else if (in_beat.half_carry_in) begin
        daa_adj = calu_pkg::DAA_SUB_LO;
      end
    end else begin
      if (in_beat.carry_in || (a >= calu_pkg::DAA_HI_LIMIT)) begin
        daa_adj = calu_pkg::DAA_ADD_HI;
        daa_c   = 1'b1;
      end
      if (in_beat.half_carry_in || (a[3:0] >= calu_pkg::DAA_LO_LIMIT)) begin
        daa_adj = daa_adj | calu_pkg::DAA_ADD_LO;
      end
    end
  end

  // bundle for the select stage
  always_comb begin
    mid_beat.op        = in_beat.op;
    mid_beat.a16       = a16;
    mid_beat.bit_index = in_beat.bit_index;
    mid_beat.zi        = in_beat.zero_in;
    mid_beat.ni        = in_beat.subtract_in;
    mid_beat.hi        = in_beat.half_carry_in;
    mid_beat.ci        = in_beat.carry_in;
    mid_beat.add9      = add9;
    mid_beat.add_h     = a[4] ^ b[4] ^ add9[4];
    mid_beat.sub9      = sub9;
    mid_beat.sub_h     = a[4] ^ b[4] ^ sub9[4];
    mid_beat.and8      = a & b;
    mid_beat.xor8      = a ^ b;
    mid_beat.or8       = a | b;
    mid_beat.inc8      = a + 8'h01;
    mid_beat.dec8      = a - 8'h01;
    mid_beat.sum17     = sum17;
    mid_beat.sum_h     = a16[12] ^ b16[12] ^ sum17[12];
    mid_beat.sp16      = a16 + {{8{b[7]}}, b};
    mid_beat.inc16     = a16 + 16'h0001;
    mid_beat.dec16     = a16 - 16'h0001;
    mid_beat.daa8      = a + daa_adj;
    mid_beat.daa_c     = daa_c;
  end

endmodule

FILE: sv/cpu_alu_with_flags.sv
// cpu_alu_with_flags: three stage pipelined 8/16 bit alu with z/n/h/c flags
// depends on calu_pkg and calu_arith
//
//   channel  ports                         beat type
//   input    in_valid, in_stall, in_data   calu_pkg::in_t
//   result   out_valid, out_stall, out_data calu_pkg::out_t
//
// a beat passes the input register, the adder register (calu_arith) and the
// select/flag register driving the outputs; out_valid is its valid bit.
// one beat can be taken every cycle unless every stage is full and out_stall
// is high; the adder stage sets the cycle time.
// rst_n empties all three stages; payload registers are not reset.
// out_stall holds the pipeline, in_stall rises only when every stage is full.
module cpu_alu_with_flags (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  calu_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output calu_pkg::out_t out_data
);

  logic           v1_r;
  logic           v1_nxt;
  logic           v2_r;
  logic           v2_nxt;
  logic           v3_r;
  logic           v3_nxt;
  logic           adv1;
  logic           adv2;
  logic           adv3;
  calu_pkg::in_t  s1_r;
  calu_pkg::mid_t mid_w;
  calu_pkg::mid_t s2_r;
  calu_pkg::out_t res_nxt;
  calu_pkg::out_t res_r;

  // stage advance: a stage loads when empty or when its content moves on
  assign adv3     = !v3_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  assign v1_nxt = adv1 ? in_valid : v1_r;
  assign v2_nxt = adv2 ? v1_r     : v2_r;
  assign v3_nxt = adv3 ? v2_r     : v3_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // adder stage
  calu_arith u_arith (
    .in_beat  (s1_r),
    .mid_beat (mid_w)
  );

  // result select and flags
  always_comb begin
    logic [7:0] a;
    logic [7:0] sh8;
    logic       shc;
    logic [7:0] mask;
    a    = s2_r.a16[7:0];
    mask = 8'h01 << s2_r.bit_index;
    sh8  = 8'h00;
    shc  = 1'b0;
    case (s2_r.op)
      calu_pkg::OP_RLCA, calu_pkg::OP_RLC: begin
        sh8 = {a[6:0], a[7]};
        shc = a[7];
      end
      calu_pkg::OP_RRCA, calu_pkg::OP_RRC: begin
        sh8 = {a[0], a[7:1]};
        shc = a[0];
      end
      calu_pkg::OP_RLA, calu_pkg::OP_RL: begin
        sh8 = {a[6:0], s2_r.ci};
        shc = a[7];
      end
      calu_pkg::OP_RRA, calu_pkg::OP_RR: begin
        sh8 = {s2_r.ci, a[7:1]};
        shc = a[0];
      end
      calu_pkg::OP_SLA: begin
        sh8 = {a[6:0], 1'b0};
        shc = a[7];
      end
      calu_pkg::OP_SRA: begin
        sh8 = {a[7], a[7:1]};
        shc = a[0];
      end
      calu_pkg::OP_SRL: begin
        sh8 = {1'b0, a[7:1]};
        shc = a[0];
      end
      calu_pkg::OP_SWAP: begin
        sh8 = {a[3:0], a[7:4]};
        shc = 1'b0;
      end
      default: begin
        sh8 = 8'h00;
        shc = 1'b0;
      end
    endcase

    res_nxt.result         = s2_r.a16;
    res_nxt.zero_out       = s2_r.zi;
    res_nxt.subtract_out   = s2_r.ni;
    res_nxt.half_carry_out = s2_r.hi;
    res_nxt.carry_out      = s2_r.ci;
    case (s2_r.op)
      calu_pkg::OP_ADD, calu_pkg::OP_ADC: begin
        res_nxt.result         = {8'h00, s2_r.add9[7:0]};
        res_nxt.zero_out       = (s2_r.add9[7:0] == 8'h00);
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = s2_r.add_h;
        res_nxt.carry_out      = s2_r.add9[8];
      end
      calu_pkg::OP_SUB, calu_pkg::OP_SBC: begin
        res_nxt.result         = {8'h00, s2_r.sub9[7:0]};
        res_nxt.zero_out       = (s2_r.sub9[7:0] == 8'h00);
        res_nxt.subtract_out   = 1'b1;
        res_nxt.half_carry_out = s2_r.sub_h;
        res_nxt.carry_out      = s2_r.sub9[8];
      end
      calu_pkg::OP_CP: begin
        res_nxt.zero_out       = (s2_r.sub9[7:0] == 8'h00);
        res_nxt.subtract_out   = 1'b1;
        res_nxt.half_carry_out = s2_r.sub_h;
        res_nxt.carry_out      = s2_r.sub9[8];
      end
      calu_pkg::OP_AND: begin
        res_nxt.result         = {8'h00, s2_r.and8};
        res_nxt.zero_out       = (s2_r.and8 == 8'h00);
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = 1'b1;
        res_nxt.carry_out      = 1'b0;
      end
      calu_pkg::OP_XOR: begin
        res_nxt.result         = {8'h00, s2_r.xor8};
        res_nxt.zero_out       = (s2_r.xor8 == 8'h00);
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = 1'b0;
        res_nxt.carry_out      = 1'b0;
      end
      calu_pkg::OP_OR: begin
        res_nxt.result         = {8'h00, s2_r.or8};
        res_nxt.zero_out       = (s2_r.or8 == 8'h00);
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = 1'b0;
        res_nxt.carry_out      = 1'b0;
      end
      calu_pkg::OP_INC: begin
        res_nxt.result         = {8'h00, s2_r.inc8};
        res_nxt.zero_out       = (s2_r.inc8 == 8'h00);
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = (a[3:0] == 4'hf);
      end
      calu_pkg::OP_DEC: begin
        res_nxt.result         = {8'h00, s2_r.dec8};
        res_nxt.zero_out       = (s2_r.dec8 == 8'h00);
        res_nxt.subtract_out   = 1'b1;
        res_nxt.half_carry_out = (a[3:0] == 4'h0);
      end
      calu_pkg::OP_ADD16: begin
        res_nxt.result         = s2_r.sum17[15:0];
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = s2_r.sum_h;
        res_nxt.carry_out      = s2_r.sum17[16];
      end
      calu_pkg::OP_ADC16: begin
        res_nxt.result         = s2_r.sum17[15:0];
        res_nxt.zero_out       = (s2_r.sum17[15:0] == 16'h0000);
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = s2_r.sum_h;
        res_nxt.carry_out      = s2_r.sum17[16];
      end
      calu_pkg::OP_ADDSP: begin
        res_nxt.result         = s2_r.sp16;
        res_nxt.zero_out       = 1'b0;
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = s2_r.add_h;
        res_nxt.carry_out      = s2_r.add9[8];
      end
      calu_pkg::OP_INC16: begin
        res_nxt.result = s2_r.inc16;
      end
      calu_pkg::OP_DEC16: begin
        res_nxt.result = s2_r.dec16;
      end
      calu_pkg::OP_DAA: begin
        res_nxt.result         = {8'h00, s2_r.daa8};
        res_nxt.zero_out       = (s2_r.daa8 == 8'h00);
        res_nxt.half_carry_out = 1'b0;
        res_nxt.carry_out      = s2_r.daa_c;
      end
      calu_pkg::OP_CPL: begin
        res_nxt.result         = {8'h00, ~a};
        res_nxt.subtract_out   = 1'b1;
        res_nxt.half_carry_out = 1'b1;
      end
      calu_pkg::OP_CCF: begin
        res_nxt.result         = {8'h00, a};
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = 1'b0;
        res_nxt.carry_out      = !s2_r.ci;
      end
      calu_pkg::OP_SCF: begin
        res_nxt.result         = {8'h00, a};
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = 1'b0;
        res_nxt.carry_out      = 1'b1;
      end
      // accumulator rotates always clear z
      calu_pkg::OP_RLCA, calu_pkg::OP_RRCA, calu_pkg::OP_RLA, calu_pkg::OP_RRA: begin
        res_nxt.result         = {8'h00, sh8};
        res_nxt.zero_out       = 1'b0;
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = 1'b0;
        res_nxt.carry_out      = shc;
      end
      calu_pkg::OP_RLC, calu_pkg::OP_RRC, calu_pkg::OP_RL, calu_pkg::OP_RR,
      calu_pkg::OP_SLA, calu_pkg::OP_SRA, calu_pkg::OP_SRL, calu_pkg::OP_SWAP: begin
        res_nxt.result         = {8'h00, sh8};
        res_nxt.zero_out       = (sh8 == 8'h00);
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = 1'b0;
        res_nxt.carry_out      = shc;
      end
      calu_pkg::OP_BIT: begin
        res_nxt.zero_out       = !a[s2_r.bit_index];
        res_nxt.subtract_out   = 1'b0;
        res_nxt.half_carry_out = 1'b1;
      end
      calu_pkg::OP_SET: begin
        res_nxt.result = {8'h00, a | mask};
      end
      calu_pkg::OP_RES: begin
        res_nxt.result = {8'h00, a & ~mask};
      end
      default: begin
        res_nxt.result = s2_r.a16;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_r <= in_data;
    end
    if (adv2 && v1_r) begin
      s2_r <= mid_w;
    end
    if (adv3 && v2_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = res_r;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_stall))
    else $error("input stalled with a free stage");

  a_stage2_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && adv3) |=> v3_r)
    else $error("beat lost between adder and output stage");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted beat not held in stage 1");

  a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !adv2) |=> (v1_r && $stable(s1_r)))
    else $error("stage 1 changed while held");

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking bench for the cpu_alu_with_flags pipeline,
// directed corners then random beats; depends on calu_pkg and the rtl
module tb_top;

  localparam int RANDOM_BEATS = 900;
  localparam int CALM_TAIL    = 100;
  localparam int IDLE_LIMIT   = 500;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    calu_pkg::in_t beat;
    bit            drain_first;
  } alu_req_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  calu_pkg::in_t  in_beat = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  calu_pkg::out_t out_beat;

  alu_req_t       alu_ops_pending[$];
  calu_pkg::out_t results_due[$];
  alu_req_t       next_req;
  calu_pkg::out_t want;
  int       gap_left = 0;
  int       stall_left = 0;
  int       beats_taken = 0;
  int       results_taken = 0;
  int       fail_count = 0;
  int       quiet_cycles = 0;
  bit       op_seen[64];

  cpu_alu_with_flags dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_beat)
  );

  always #5 clk = ~clk;

  // expected result word and flags for one beat
  function automatic calu_pkg::out_t alu_outcome(calu_pkg::in_t beat);
    calu_pkg::out_t o;
    logic [7:0]  a, b, r;
    logic [8:0]  s9;
    logic [16:0] s17;
    logic [15:0] wide;
    logic        z, n, h, c, sh_c;
    bit          byte_res, shifted;
    a = beat.operand_a[7:0];
    b = beat.operand_b[7:0];
    {z, n, h, c} = {beat.zero_in, beat.subtract_in, beat.half_carry_in, beat.carry_in};
    r = '0;
    wide = beat.operand_a;
    byte_res = 1'b1;
    shifted = 1'b0;
    sh_c = 1'b0;
    case (beat.op)
      calu_pkg::OP_ADD, calu_pkg::OP_ADC: begin
        s9 = {1'b0, a} + {1'b0, b} + {8'd0, (beat.op == calu_pkg::OP_ADC) & c};
        r = s9[7:0];
        z = (r == 8'h00);
        n = 1'b0;
        h = a[4] ^ b[4] ^ s9[4];
        c = s9[8];
      end
      calu_pkg::OP_SUB, calu_pkg::OP_SBC, calu_pkg::OP_CP: begin
        s9 = {1'b0, a} - {1'b0, b} - {8'd0, (beat.op == calu_pkg::OP_SBC) & c};
        r = s9[7:0];
        z = (r == 8'h00);
        n = 1'b1;
        h = a[4] ^ b[4] ^ s9[4];
        c = s9[8];
        // compare leaves the whole register untouched
        if (beat.op == calu_pkg::OP_CP) byte_res = 1'b0;
      end
      calu_pkg::OP_AND: begin
        r = a & b;
        z = (r == 8'h00);
        {n, h, c} = 3'b010;
      end
      calu_pkg::OP_XOR, calu_pkg::OP_OR: begin
        r = (beat.op == calu_pkg::OP_XOR) ? (a ^ b) : (a | b);
        z = (r == 8'h00);
        {n, h, c} = 3'b000;
      end
      calu_pkg::OP_INC: begin
        r = a + 8'd1;
        z = (r == 8'h00);
        n = 1'b0;
        h = (a[3:0] == 4'hf);
      end
      calu_pkg::OP_DEC: begin
        r = a - 8'd1;
        z = (r == 8'h00);
        n = 1'b1;
        h = (a[3:0] == 4'h0);
      end
      calu_pkg::OP_ADD16, calu_pkg::OP_ADC16: begin
        byte_res = 1'b0;
        s17 = {1'b0, beat.operand_a} + {1'b0, beat.operand_b}
            + {16'd0, (beat.op == calu_pkg::OP_ADC16) & c};
        wide = s17[15:0];
        if (beat.op == calu_pkg::OP_ADC16) z = (wide == 16'h0000);
        n = 1'b0;
        h = beat.operand_a[12] ^ beat.operand_b[12] ^ s17[12];
        c = s17[16];
      end
      calu_pkg::OP_ADDSP: begin
        // signed byte offset, flags from the unsigned low byte add
        byte_res = 1'b0;
        wide = beat.operand_a + {{8{b[7]}}, b};
        s9 = {1'b0, a} + {1'b0, b};
        h = a[4] ^ b[4] ^ s9[4];
        c = s9[8];
        {z, n} = 2'b00;
      end
      calu_pkg::OP_INC16: begin
        byte_res = 1'b0;
        wide = beat.operand_a + 16'd1;
      end
      calu_pkg::OP_DEC16: begin
        byte_res = 1'b0;
        wide = beat.operand_a - 16'd1;
      end
      calu_pkg::OP_DAA: begin
        r = a;
        if (n) begin
          if (c && h) r = r + calu_pkg::DAA_SUB_BOTH;
          else if (c) r = r + calu_pkg::DAA_SUB_HI;
          else if (h) r = r + calu_pkg::DAA_SUB_LO;
        end else begin
          if (c || a >= calu_pkg::DAA_HI_LIMIT) begin
            r = r + calu_pkg::DAA_ADD_HI;
            c = 1'b1;
          end
          if (h || a[3:0] >= calu_pkg::DAA_LO_LIMIT) r = r + calu_pkg::DAA_ADD_LO;
        end
        z = (r == 8'h00);
        h = 1'b0;
      end
      calu_pkg::OP_CPL: begin
        r = ~a;
        {n, h} = 2'b11;
      end
      calu_pkg::OP_CCF: begin
        r = a;
        {n, h} = 2'b00;
        c = ~c;
      end
      calu_pkg::OP_SCF: begin
        r = a;
        {n, h, c} = 3'b001;
      end
      calu_pkg::OP_RLCA, calu_pkg::OP_RLC: begin
        shifted = 1'b1;
        r = {a[6:0], a[7]};
        sh_c = a[7];
      end
      calu_pkg::OP_RRCA, calu_pkg::OP_RRC: begin
        shifted = 1'b1;
        r = {a[0], a[7:1]};
        sh_c = a[0];
      end
      calu_pkg::OP_RLA, calu_pkg::OP_RL: begin
        shifted = 1'b1;
        r = {a[6:0], c};
        sh_c = a[7];
      end
      calu_pkg::OP_RRA, calu_pkg::OP_RR: begin
        shifted = 1'b1;
        r = {c, a[7:1]};
        sh_c = a[0];
      end
      calu_pkg::OP_SLA: begin
        shifted = 1'b1;
        r = {a[6:0], 1'b0};
        sh_c = a[7];
      end
      calu_pkg::OP_SRA: begin
        shifted = 1'b1;
        r = {a[7], a[7:1]};
        sh_c = a[0];
      end
      calu_pkg::OP_SRL: begin
        shifted = 1'b1;
        r = {1'b0, a[7:1]};
        sh_c = a[0];
      end
      calu_pkg::OP_SWAP: begin
        shifted = 1'b1;
        r = {a[3:0], a[7:4]};
        sh_c = 1'b0;
      end
      calu_pkg::OP_BIT: begin
        byte_res = 1'b0;
        z = ~a[beat.bit_index];
        {n, h} = 2'b01;
      end
      calu_pkg::OP_SET: r = a | (8'd1 << beat.bit_index);
      calu_pkg::OP_RES: r = a & ~(8'd1 << beat.bit_index);
      // unused codes pass everything through
      default: byte_res = 1'b0;
    endcase
    if (shifted) begin
      z = (r == 8'h00);
      {n, h} = 2'b00;
      c = sh_c;
    end
    // accumulator rotates always clear zero
    if (beat.op >= calu_pkg::OP_RLCA && beat.op <= calu_pkg::OP_RRA) z = 1'b0;
    o.result = byte_res ? {8'h00, r} : wide;
    o.zero_out = z;
    o.subtract_out = n;
    o.half_carry_out = h;
    o.carry_out = c;
    return o;
  endfunction

  task automatic add_op(calu_pkg::op_code_t op, logic [15:0] a, logic [15:0] b,
                        logic [2:0] idx, logic [3:0] znhc, bit drain);
    alu_req_t req;
    req.beat.op = op;
    req.beat.operand_a = a;
    req.beat.operand_b = b;
    req.beat.bit_index = idx;
    {req.beat.zero_in, req.beat.subtract_in, req.beat.half_carry_in, req.beat.carry_in} = znhc;
    req.drain_first = drain;
    alu_ops_pending.push_back(req);
  endtask

  // operand word, weighted towards byte and nibble corners
  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 9))
      0: w = 16'h0000;
      1: w = 16'hffff;
      2: w[7:0] = 8'h00;
      3: w[7:0] = 8'hff;
      4: w[7:0] = 8'h80;
      5: w[3:0] = 4'hf;
      default: ;
    endcase
    return w;
  endfunction

  // random idling off near the end and in every fourth stretch of 64 beats
  function automatic bit idle_allowed();
    return alu_ops_pending.size() > CALM_TAIL && ((beats_taken / 64) % 4) != 3;
  endfunction

  task automatic log_fail(string what, calu_pkg::out_t w, calu_pkg::out_t g);
    fail_count++;
    if (fail_count <= 10)
      $display("error %0d %s: want %04h z%0b n%0b h%0b c%0b, got %04h z%0b n%0b h%0b c%0b",
               fail_count, what, w.result, w.zero_out, w.subtract_out, w.half_carry_out,
               w.carry_out, g.result, g.zero_out, g.subtract_out, g.half_carry_out,
               g.carry_out);
  endtask

  // driver: present queued beats, record expectations on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        results_due.push_back(alu_outcome(in_beat));
        op_seen[in_beat.op] = 1'b1;
        beats_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (alu_ops_pending.size() == 0 ||
                     (alu_ops_pending[0].drain_first && results_due.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 11) - 1;
          in_valid <= 1'b0;
        end else begin
          next_req = alu_ops_pending.pop_front();
          in_beat <= next_req.beat;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor: random back-pressure and in-order field checks
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_taken++;
        if (results_due.size() == 0) begin
          log_fail("result with nothing outstanding", '0, out_beat);
        end else begin
          want = results_due.pop_front();
          if (out_beat.result !== want.result || out_beat.zero_out !== want.zero_out ||
              out_beat.subtract_out !== want.subtract_out ||
              out_beat.half_carry_out !== want.half_carry_out ||
              out_beat.carry_out !== want.carry_out)
            log_fail("result mismatch", want, out_beat);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    calu_pkg::op_code_t op_pick;
    int                 ops_hit;
    // directed corners, at least one per operation, plus one unused code
    add_op(calu_pkg::OP_ADD,   16'h00ff, 16'h0001, 3'd0, 4'b0000, 1'b0);
    add_op(calu_pkg::OP_ADC,   16'hff0f, 16'hff00, 3'd0, 4'b0001, 1'b0);
    add_op(calu_pkg::OP_SUB,   16'h0000, 16'h0001, 3'd0, 4'b0000, 1'b0);
    add_op(calu_pkg::OP_SBC,   16'h0010, 16'h000f, 3'd0, 4'b0001, 1'b0);
    add_op(calu_pkg::OP_AND,   16'h00f0, 16'h000f, 3'd0, 4'b0001, 1'b0);
    add_op(calu_pkg::OP_XOR,   16'hffff, 16'h00ff, 3'd0, 4'b1111, 1'b0);
    add_op(calu_pkg::OP_OR,    16'h0000, 16'h0080, 3'd0, 4'b1111, 1'b0);
    add_op(calu_pkg::OP_CP,    16'hff42, 16'h0042, 3'd0, 4'b0000, 1'b0);
    add_op(calu_pkg::OP_INC,   16'h00ff, 16'h0000, 3'd0, 4'b0101, 1'b0);
    add_op(calu_pkg::OP_DEC,   16'h0000, 16'h0000, 3'd0, 4'b1000, 1'b0);
    add_op(calu_pkg::OP_ADD16, 16'hffff, 16'h0001, 3'd0, 4'b0100, 1'b0);
    add_op(calu_pkg::OP_ADC16, 16'h0fff, 16'hf000, 3'd0, 4'b0001, 1'b0);
    add_op(calu_pkg::OP_ADDSP, 16'h00ff, 16'hff81, 3'd0, 4'b1100, 1'b0);
    add_op(calu_pkg::OP_INC16, 16'hffff, 16'h0000, 3'd0, 4'b1010, 1'b0);
    add_op(calu_pkg::OP_DEC16, 16'h0000, 16'hffff, 3'd0, 4'b0101, 1'b0);
    add_op(calu_pkg::OP_DAA,   16'h009a, 16'h0000, 3'd0, 4'b0000, 1'b0);
    add_op(calu_pkg::OP_DAA,   16'h0000, 16'h0000, 3'd0, 4'b0111, 1'b0);
    add_op(calu_pkg::OP_CPL,   16'ha5a5, 16'h0000, 3'd0, 4'b1001, 1'b0);
    add_op(calu_pkg::OP_CCF,   16'hff3c, 16'h0000, 3'd0, 4'b1111, 1'b0);
    add_op(calu_pkg::OP_SCF,   16'h1200, 16'h0000, 3'd0, 4'b0110, 1'b0);
    add_op(calu_pkg::OP_RLCA,  16'h0080, 16'h0000, 3'd0, 4'b1000, 1'b0);
    add_op(calu_pkg::OP_RRCA,  16'h0000, 16'h0000, 3'd0, 4'b0110, 1'b0);
    add_op(calu_pkg::OP_RLA,   16'h0080, 16'h0000, 3'd0, 4'b0000, 1'b0);
    add_op(calu_pkg::OP_RRA,   16'h0001, 16'h0000, 3'd0, 4'b0001, 1'b0);
    add_op(calu_pkg::OP_RLC,   16'hff00, 16'h0000, 3'd0, 4'b0111, 1'b0);
    add_op(calu_pkg::OP_RRC,   16'h0001, 16'h0000, 3'd0, 4'b0000, 1'b0);
    add_op(calu_pkg::OP_RL,    16'h0080, 16'h0000, 3'd0, 4'b0000, 1'b0);
    add_op(calu_pkg::OP_RR,    16'h0001, 16'h0000, 3'd0, 4'b0000, 1'b0);
    add_op(calu_pkg::OP_SLA,   16'h0080, 16'h0000, 3'd0, 4'b0000, 1'b0);
    add_op(calu_pkg::OP_SRA,   16'h0081, 16'h0000, 3'd0, 4'b0000, 1'b0);
    add_op(calu_pkg::OP_SRL,   16'h0001, 16'h0000, 3'd0, 4'b0000, 1'b0);
    add_op(calu_pkg::OP_SWAP,  16'h00f0, 16'h0000, 3'd0, 4'b1111, 1'b0);
    add_op(calu_pkg::OP_BIT,   16'hff7f, 16'h0000, 3'd7, 4'b0001, 1'b0);
    add_op(calu_pkg::OP_SET,   16'hff00, 16'h0000, 3'd0, 4'b1010, 1'b0);
    add_op(calu_pkg::OP_RES,   16'h00ff, 16'h0000, 3'd7, 4'b0101, 1'b0);
    add_op(calu_pkg::op_code_t'(63), 16'hbeef, 16'hffff, 3'd7, 4'b1010, 1'b0);
    // random beats; the sender drains the pipe before the first and halfway
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if ($urandom_range(0, 15) == 0)
        op_pick = calu_pkg::op_code_t'($urandom_range(calu_pkg::OP_RES + 1, 63));
      else
        op_pick = calu_pkg::op_code_t'($urandom_range(0, calu_pkg::OP_RES));
      add_op(op_pick, pick_word(), pick_word(), 3'($urandom_range(0, 7)),
             4'($urandom_range(0, 15)), i == 0 || i == RANDOM_BEATS / 2);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // wait for the last beat to go in and every result to come back
    while (alu_ops_pending.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (results_due.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", results_due.size());
    end
    ops_hit = 0;
    foreach (op_seen[k]) ops_hit += op_seen[k];
    $display("%0d beats issued, %0d results checked field by field",
             beats_taken, results_taken);
    $display("%0d of 64 op codes seen, with random gaps and back-pressure", ops_hit);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
